@@ rtl/rlh_pkg.sv @@
package rlh_pkg;

  // Counter width of every bin and every running maximum
  localparam int COUNT_BITS = 24;
  localparam int OUT_W      = 24;
  localparam int BINS       = 256;
  localparam int BIN_W      = $clog2(BINS);
  localparam int NUM_CH     = 4;

  // Bar height divider: quotient bits and dividend width (count * 100)
  localparam int DIV_BITS   = 7;
  localparam int NUM_W      = COUNT_BITS + DIV_BITS;
  localparam int STEP_W     = $clog2(DIV_BITS);

  // Request queue between front and back
  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = $clog2(QDEPTH);

  typedef logic [COUNT_BITS-1:0] cnt_t;

  localparam cnt_t CNT_MAX = '1;

  localparam logic [DIV_BITS-1:0] HEIGHT_FULL = 7'd100;

  // Request modes
  localparam logic MODE_PIXEL = 1'b0;
  localparam logic MODE_READ  = 1'b1;

  // Channel codes, also bank numbers
  localparam logic [1:0] CH_LUMA  = 2'd0;
  localparam logic [1:0] CH_RED   = 2'd1;
  localparam logic [1:0] CH_GREEN = 2'd2;
  localparam logic [1:0] CH_BLUE  = 2'd3;

  typedef struct packed {
    logic            mode;
    logic [7:0]      red;
    logic [7:0]      green;
    logic [7:0]      blue;
    logic [BIN_W-1:0] bin_index;
    logic [1:0]      channel;
  } rlh_in_t;

  typedef struct packed {
    logic [OUT_W-1:0]    bin_count;
    logic [OUT_W-1:0]    norm_max;
    logic [DIV_BITS-1:0] bar_height;
  } rlh_out_t;

  typedef enum logic [1:0] {
    OP_LUMA,
    OP_RGB,
    OP_READ
  } op_t;

  // One classified request as held in the queue
  typedef struct packed {
    op_t                         op;
    logic [1:0]                  ch;
    logic [NUM_CH-1:0][BIN_W-1:0] addr;
  } q_entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_UPD,
    S_DIV,
    S_OUT
  } back_state_t;

  // Fit a counter value onto a result field
  function automatic logic [OUT_W-1:0] to_out(input cnt_t v);
    logic [OUT_W+COUNT_BITS-1:0] w;
    w = {{OUT_W{1'b0}}, v};
    return w[OUT_W-1:0];
  endfunction

endpackage

@@ rtl/rlh_front.sv @@
module rlh_front
  import rlh_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  rlh_in_t   in_req,
  input  logic      cfg_we,
  input  logic      cfg_wdata,
  input  logic      clearing,
  input  q_status_t q_stat,
  output logic      busy,
  output logic      push,
  output q_entry_t  entry
);

  logic        gray_mode_r;
  logic        gray_mode_nxt;
  logic [12:0] luma_sum;

  // Hold the mode register
  always_comb begin
    gray_mode_nxt = cfg_we ? cfg_wdata : gray_mode_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gray_mode_r <= 1'b0;
    end else begin
      gray_mode_r <= gray_mode_nxt;
    end
  end

  // Take requests only when the queue has room and the banks are clear
  assign busy = clearing | q_stat.full;
  assign push = start & ~busy;

  // Luminance bin: (r*11 + g*16 + b*5) / 32
  assign luma_sum = {5'd0, in_req.red} * 13'd11
                  + {1'b0, in_req.green, 4'd0}
                  + {5'd0, in_req.blue} * 13'd5;

  // Classify the request and work out each bank's address
  always_comb begin
    entry.ch = in_req.channel;
    if (in_req.mode == MODE_READ) begin
      entry.op             = OP_READ;
      entry.addr[CH_LUMA]  = in_req.bin_index;
      entry.addr[CH_RED]   = in_req.bin_index;
      entry.addr[CH_GREEN] = in_req.bin_index;
      entry.addr[CH_BLUE]  = in_req.bin_index;
    end else begin
      entry.op             = gray_mode_r ? OP_LUMA : OP_RGB;
      entry.addr[CH_LUMA]  = luma_sum[12:5];
      entry.addr[CH_RED]   = in_req.red;
      entry.addr[CH_GREEN] = in_req.green;
      entry.addr[CH_BLUE]  = in_req.blue;
    end
  end

endmodule

@@ rtl/rlh_queue.sv @@
module rlh_queue
  import rlh_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  q_entry_t  wr_entry,
  input  logic      pop,
  output q_entry_t  head,
  output q_status_t q_stat
);

  q_entry_t            slot_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]     fill_r, fill_nxt;

  assign head         = slot_r[rd_ptr_r];
  assign q_stat.empty = (fill_r == '0);
  assign q_stat.full  = (fill_r == (QPTR_W+1)'(QDEPTH));

  // Advance pointers and fill level
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (pop && !push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // Store the pushed request
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= wr_entry;
    end
  end

endmodule

@@ rtl/rlh_back.sv @@
module rlh_back
  import rlh_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  q_entry_t  head,
  input  q_status_t q_stat,
  output logic      pop,
  output logic      clearing,
  output logic      out_valid,
  output rlh_out_t  out_res
);

  back_state_t         state_r, state_nxt;
  logic [BIN_W-1:0]    clr_r, clr_nxt;
  q_entry_t            item_r, item_nxt;
  cnt_t                mem [NUM_CH][BINS];
  cnt_t                rd_r [NUM_CH];
  cnt_t                max_r [NUM_CH];
  cnt_t                max_nxt [NUM_CH];
  cnt_t                bumped [NUM_CH];
  logic [NUM_CH-1:0]   we;
  logic [BIN_W-1:0]    wa [NUM_CH];
  cnt_t                wd [NUM_CH];
  cnt_t                count_r, count_nxt;
  cnt_t                mx_r, mx_nxt;
  cnt_t                count_sel;
  cnt_t                rgb_max;
  cnt_t                mx_sel;
  logic [NUM_W-1:0]    rem_r, rem_nxt;
  logic [NUM_W-1:0]    div_r, div_nxt;
  logic [DIV_BITS-1:0] q_r, q_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic                out_valid_r, out_valid_nxt;
  rlh_out_t            out_res_r, out_res_nxt;

  assign clearing  = (state_r == S_CLEAR);
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  // Saturating increment of each bank's read data
  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      bumped[c] = (rd_r[c] == CNT_MAX) ? rd_r[c] : rd_r[c] + cnt_t'(1);
    end
  end

  // Select the read count and the normalizing maximum
  always_comb begin
    count_sel = rd_r[item_r.ch];
    rgb_max   = max_r[CH_RED];
    if (max_r[CH_GREEN] > rgb_max) begin
      rgb_max = max_r[CH_GREEN];
    end
    if (max_r[CH_BLUE] > rgb_max) begin
      rgb_max = max_r[CH_BLUE];
    end
    mx_sel = (item_r.ch == CH_LUMA) ? max_r[CH_LUMA] : rgb_max;
  end

  // Sequence clearing, bin updates, bin reads with their division, and output
  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    item_nxt      = item_r;
    count_nxt     = count_r;
    mx_nxt        = mx_r;
    rem_nxt       = rem_r;
    div_nxt       = div_r;
    q_nxt         = q_r;
    step_nxt      = step_r;
    out_valid_nxt = 1'b0;
    out_res_nxt   = out_res_r;
    pop           = 1'b0;
    we            = '0;
    for (int c = 0; c < NUM_CH; c++) begin
      max_nxt[c] = max_r[c];
      wa[c]      = item_r.addr[c];
      wd[c]      = bumped[c];
    end

    case (state_r)
      S_CLEAR: begin
        we = '1;
        for (int c = 0; c < NUM_CH; c++) begin
          wa[c] = clr_r;
          wd[c] = '0;
        end
        clr_nxt = clr_r + 1'b1;
        if (clr_r == BIN_W'(BINS-1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (!q_stat.empty) begin
          pop       = 1'b1;
          item_nxt  = head;
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        case (item_r.op)
          OP_LUMA: begin
            we[CH_LUMA] = 1'b1;
            if (bumped[CH_LUMA] > max_r[CH_LUMA]) begin
              max_nxt[CH_LUMA] = bumped[CH_LUMA];
            end
            state_nxt = S_IDLE;
          end
          OP_RGB: begin
            for (int c = 1; c < NUM_CH; c++) begin
              we[c] = 1'b1;
              if (bumped[c] > max_r[c]) begin
                max_nxt[c] = bumped[c];
              end
            end
            state_nxt = S_IDLE;
          end
          OP_READ: begin
            count_nxt = count_sel;
            mx_nxt    = mx_sel;
            rem_nxt   = NUM_W'(count_sel) * NUM_W'(HEIGHT_FULL);
            div_nxt   = NUM_W'(mx_sel) << (DIV_BITS - 1);
            q_nxt     = '0;
            step_nxt  = STEP_W'(DIV_BITS - 1);
            state_nxt = S_DIV;
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_DIV: begin
        // One restoring step: one quotient bit per cycle
        if (rem_r >= div_r) begin
          rem_nxt = rem_r - div_r;
          q_nxt   = {q_r[DIV_BITS-2:0], 1'b1};
        end else begin
          q_nxt   = {q_r[DIV_BITS-2:0], 1'b0};
        end
        div_nxt = div_r >> 1;
        if (step_r == '0) begin
          state_nxt = S_OUT;
        end else begin
          step_nxt = step_r - 1'b1;
        end
      end
      S_OUT: begin
        out_valid_nxt          = 1'b1;
        out_res_nxt.bin_count  = to_out(count_r);
        out_res_nxt.norm_max   = to_out(mx_r);
        if (mx_r == '0) begin
          out_res_nxt.bar_height = HEIGHT_FULL;
        end else if (q_r >= HEIGHT_FULL) begin
          out_res_nxt.bar_height = '0;
        end else begin
          out_res_nxt.bar_height = HEIGHT_FULL - q_r;
        end
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      for (int c = 0; c < NUM_CH; c++) begin
        max_r[c] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      for (int c = 0; c < NUM_CH; c++) begin
        max_r[c] <= max_nxt[c];
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    item_r    <= item_nxt;
    count_r   <= count_nxt;
    mx_r      <= mx_nxt;
    rem_r     <= rem_nxt;
    div_r     <= div_nxt;
    q_r       <= q_nxt;
    step_r    <= step_nxt;
    out_res_r <= out_res_nxt;
  end

  // Bin banks: one write and one registered read per bank each cycle
  always_ff @(posedge clk) begin
    for (int c = 0; c < NUM_CH; c++) begin
      if (we[c]) begin
        mem[c][wa[c]] <= wd[c];
      end
      rd_r[c] <= mem[c][head.addr[c]];
    end
  end

endmodule

@@ rtl/rgb_luma_histogram.sv @@
// Four 256-bin pixel histograms (luminance, red, green, blue) with running
// per-channel maxima. A pixel request (mode 0) bumps the luminance bin in gray
// mode or the red, green and blue bins in color mode; it gives no result. A
// read request (mode 1) gives one result: the bin count, the normalizing
// maximum and the bar height 100 - floor(100*count/max). Requests enter a
// two-deep queue; the back end works one request at a time from it, while
// the queue takes new ones until full: a pixel goes through a registered
// bank read, then a saturating write and maximum update; a read goes
// through a bank read, operand setup, a restoring divider and an output
// register. busy rises only while the queue is full or the banks are
// being cleared. After reset the banks are cleared one address per cycle:
// busy stays high until all 256 addresses are cleared. Results appear with
// out_valid for exactly one cycle and cannot be held off. Write gray_mode
// only while no request is pending.
module rgb_luma_histogram
  import rlh_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  rlh_in_t  in_req,
  output logic     out_valid,
  output rlh_out_t out_res,
  input  logic     cfg_we,
  input  logic     cfg_wdata
);

  logic      push;
  logic      pop;
  logic      clearing;
  q_entry_t  entry;
  q_entry_t  head;
  q_status_t q_stat;

  rlh_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .in_req   (in_req),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .clearing (clearing),
    .q_stat   (q_stat),
    .busy     (busy),
    .push     (push),
    .entry    (entry)
  );

  rlh_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_entry(entry),
    .pop     (pop),
    .head    (head),
    .q_stat  (q_stat)
  );

  rlh_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (head),
    .q_stat   (q_stat),
    .pop      (pop),
    .clearing (clearing),
    .out_valid(out_valid),
    .out_res  (out_res)
  );

endmodule

@@ rtl/rlh_checker.sv @@
module rlh_checker
  import rlh_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     busy,
  input logic     out_valid,
  input rlh_out_t out_res
);

  // Banks are cleared right after reset
  a_clear_after_reset: assert property (@(posedge clk)
    $rose(rst_n) |-> busy)
    else $error("busy low right after reset");

  // A result never lasts more than one cycle
  a_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held");

  // A bin never holds more than the maximum it is scaled by
  a_count_le_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_res.bin_count <= out_res.norm_max)
    else $error("bin count above maximum");

  // Empty histogram gives a full bar
  a_zero_max: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_res.norm_max == '0) |-> out_res.bar_height == HEIGHT_FULL)
    else $error("bar height wrong for zero maximum");

  // The largest bin gives no bar
  a_full_bin: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_res.norm_max != '0 && out_res.bin_count == out_res.norm_max)
      |-> out_res.bar_height == '0)
    else $error("bar height wrong for largest bin");

endmodule

bind rgb_luma_histogram rlh_checker u_rlh_checker (.*);
